### rtl/mieu_pkg.sv
package mieu_pkg;

  // input item kinds
  localparam logic [1:0] KIND_EXEC = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_BOOT = 2'd2;

  // memory / syscall request codes
  localparam logic [2:0] REQ_NONE = 3'd0;
  localparam logic [2:0] REQ_LB   = 3'd1;
  localparam logic [2:0] REQ_LBU  = 3'd2;
  localparam logic [2:0] REQ_LW   = 3'd3;
  localparam logic [2:0] REQ_SB   = 3'd4;
  localparam logic [2:0] REQ_SW   = 3'd5;
  localparam logic [2:0] REQ_SYS  = 3'd6;

  // pending load flavor
  localparam logic [1:0] LK_LB  = 2'd0;
  localparam logic [1:0] LK_LBU = 2'd1;
  localparam logic [1:0] LK_LW  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_START_PC = 2'd0;
  localparam logic [1:0] CFG_GP       = 2'd1;
  localparam logic [1:0] CFG_SP       = 2'd2;

  // major opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  // REGIMM rt codes
  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  localparam logic [4:0] REG_V0 = 5'd2;
  localparam logic [4:0] REG_GP = 5'd28;
  localparam logic [4:0] REG_SP = 5'd29;
  localparam logic [4:0] REG_RA = 5'd31;

  localparam logic [4:0] MD_LAST = 5'd31;

endpackage

### rtl/mips_integer_execute_unit.sv
// MIPS-I integer execute unit, one instruction (or load return / boot) per word.
// Most words are handled as a register read and then an execute; boot makes three register
// file writes, and MULT/MULTU/DIV/DIVU take 32 steps of the shared add/subtract unit
// plus a sign fix (a divide by zero skips them). One word in flight at a time.
// Reset: asynchronous, active low; all registers, HI, LO, PC and config read 0.
module mips_integer_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] instr_i,
  input  logic [31:0] load_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_pc_o,
  output logic [2:0]  request_o,
  output logic [31:0] mem_addr_o,
  output logic [31:0] store_data_o,
  output logic [15:0] syscall_code_o,
  output logic        wr_en_o,
  output logic [4:0]  wr_reg_o,
  output logic [31:0] wr_value_o,
  output logic        status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_BOOT, S_MDU, S_MFIN} state_e;

  state_e      state_q;
  logic [1:0]  kind_q;
  logic [31:0] instr_q, ld_q;
  logic [31:0] a_q, b_q;
  logic [31:0] pc_q, hi_q, lo_q;
  logic        lpend_q;
  logic [4:0]  ldest_q;
  logic [1:0]  lkind_q;
  logic [31:0] cfg_pc_q, cfg_gp_q, cfg_sp_q;
  logic [1:0]  bcnt_q;

  // register file: 32 entries, valid bits give the zero reset
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;
  logic [4:0]  rd_a, rd_b;

  // multiply / divide unit
  logic [63:0] md_acc_q, md_acc_d;
  logic [31:0] md_op_q;
  logic [4:0]  md_cnt_q;
  logic        md_div_q, md_negq_q, md_negr_q;
  logic [32:0] md_sum;
  logic [63:0] md_sh, md_prod;
  logic [31:0] md_hi, md_lo;

  // output register
  logic        out_valid_q;
  logic [31:0] o_npc_q, o_addr_q, o_sdata_q, o_wval_q;
  logic [2:0]  o_req_q;
  logic [15:0] o_code_q;
  logic        o_wen_q, o_status_q;
  logic [4:0]  o_wreg_q;
  logic        out_free;

  // execute decode results
  logic [5:0]  op, fn;
  logic [4:0]  f_rt, f_rd, f_sh;
  logic [31:0] simm, zimm, link, btgt;
  logic [31:0] e_npc, e_wval, e_addr, e_sdata, e_hiv, e_lov, e_ldv;
  logic [2:0]  e_req;
  logic [15:0] e_code;
  logic [4:0]  e_wreg;
  logic        e_wen, e_status, e_hi_we, e_lo_we;
  logic        e_md_start, e_md_div, e_md_sgn;
  logic        e_ld_set, e_ld_clr;
  logic [1:0]  e_lkind;
  logic [31:0] abs_a, abs_b;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  // read addresses: SYSCALL reads r2 on port A
  always_comb begin
    rd_b = instr_i[20:16];
    if (instr_i[31:26] == mieu_pkg::OP_SPECIAL && instr_i[5:0] == mieu_pkg::FN_SYSCALL) begin
      rd_a = mieu_pkg::REG_V0;
    end else begin
      rd_a = instr_i[25:21];
    end
  end

  // instruction decode and execute
  always_comb begin
    op   = instr_q[31:26];
    fn   = instr_q[5:0];
    f_rt = instr_q[20:16];
    f_rd = instr_q[15:11];
    f_sh = instr_q[10:6];
    simm = {{16{instr_q[15]}}, instr_q[15:0]};
    zimm = {16'h0000, instr_q[15:0]};
    link = pc_q + 32'd4;
    btgt = link + {simm[29:0], 2'b00};
    abs_a = a_q[31] ? (32'd0 - a_q) : a_q;
    abs_b = b_q[31] ? (32'd0 - b_q) : b_q;
    e_npc = link;
    e_wen = 1'b0;
    e_wreg = 5'd0;
    e_wval = 32'd0;
    e_req = mieu_pkg::REQ_NONE;
    e_addr = 32'd0;
    e_sdata = 32'd0;
    e_code = 16'd0;
    e_status = 1'b0;
    e_hi_we = 1'b0;
    e_lo_we = 1'b0;
    e_hiv = a_q;
    e_lov = a_q;
    e_md_start = 1'b0;
    e_md_div = 1'b0;
    e_md_sgn = 1'b0;
    e_ld_set = 1'b0;
    e_ld_clr = 1'b0;
    e_lkind = mieu_pkg::LK_LW;
    e_ldv = ld_q;
    case (lkind_q)
      mieu_pkg::LK_LB:  e_ldv = {{24{ld_q[7]}}, ld_q[7:0]};
      mieu_pkg::LK_LBU: e_ldv = {24'h000000, ld_q[7:0]};
      default:          e_ldv = ld_q;
    endcase
    case (kind_q)
      mieu_pkg::KIND_EXEC: begin
        if (lpend_q) begin
          e_status = 1'b1;
          e_npc = pc_q;
        end else begin
          case (op)
            mieu_pkg::OP_SPECIAL: begin
              case (fn)
                mieu_pkg::FN_ADD, mieu_pkg::FN_ADDU: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = a_q + b_q;
                end
                mieu_pkg::FN_SUB, mieu_pkg::FN_SUBU: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = a_q - b_q;
                end
                mieu_pkg::FN_AND: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = a_q & b_q;
                end
                mieu_pkg::FN_OR: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = a_q | b_q;
                end
                mieu_pkg::FN_XOR: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = a_q ^ b_q;
                end
                mieu_pkg::FN_NOR: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = ~(a_q | b_q);
                end
                mieu_pkg::FN_SLT: begin
                  e_wen = 1'b1; e_wreg = f_rd;
                  e_wval = {31'd0, $signed(a_q) < $signed(b_q)};
                end
                mieu_pkg::FN_SLTU: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = {31'd0, a_q < b_q};
                end
                mieu_pkg::FN_SLL: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = b_q << f_sh;
                end
                mieu_pkg::FN_SRL: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = b_q >> f_sh;
                end
                mieu_pkg::FN_SRA: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = $unsigned($signed(b_q) >>> f_sh);
                end
                mieu_pkg::FN_SLLV: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = b_q << a_q[4:0];
                end
                mieu_pkg::FN_SRLV: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = b_q >> a_q[4:0];
                end
                mieu_pkg::FN_SRAV: begin
                  e_wen = 1'b1; e_wreg = f_rd;
                  e_wval = $unsigned($signed(b_q) >>> a_q[4:0]);
                end
                mieu_pkg::FN_MFHI: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = hi_q;
                end
                mieu_pkg::FN_MFLO: begin
                  e_wen = 1'b1; e_wreg = f_rd; e_wval = lo_q;
                end
                mieu_pkg::FN_MTHI: e_hi_we = 1'b1;
                mieu_pkg::FN_MTLO: e_lo_we = 1'b1;
                mieu_pkg::FN_MULT: begin
                  e_md_start = 1'b1; e_md_sgn = 1'b1;
                end
                mieu_pkg::FN_MULTU: e_md_start = 1'b1;
                mieu_pkg::FN_DIV: begin
                  e_md_start = (b_q != 32'd0); e_md_div = 1'b1; e_md_sgn = 1'b1;
                end
                mieu_pkg::FN_DIVU: begin
                  e_md_start = (b_q != 32'd0); e_md_div = 1'b1;
                end
                mieu_pkg::FN_JR: e_npc = a_q;
                mieu_pkg::FN_JALR: begin
                  e_npc = a_q; e_wen = 1'b1; e_wreg = f_rd; e_wval = link;
                end
                mieu_pkg::FN_SYSCALL: begin
                  e_req = mieu_pkg::REQ_SYS; e_code = a_q[15:0];
                end
                default: ;
              endcase
            end
            mieu_pkg::OP_REGIMM: begin
              case (f_rt)
                mieu_pkg::RI_BLTZ: if (a_q[31]) e_npc = btgt;
                mieu_pkg::RI_BGEZ: if (!a_q[31]) e_npc = btgt;
                mieu_pkg::RI_BLTZAL: begin
                  if (a_q[31]) e_npc = btgt;
                  e_wen = 1'b1; e_wreg = mieu_pkg::REG_RA; e_wval = link;
                end
                mieu_pkg::RI_BGEZAL: begin
                  if (!a_q[31]) e_npc = btgt;
                  e_wen = 1'b1; e_wreg = mieu_pkg::REG_RA; e_wval = link;
                end
                default: ;
              endcase
            end
            mieu_pkg::OP_J: e_npc = {link[31:28], instr_q[25:0], 2'b00};
            mieu_pkg::OP_JAL: begin
              e_npc = {link[31:28], instr_q[25:0], 2'b00};
              e_wen = 1'b1; e_wreg = mieu_pkg::REG_RA; e_wval = link;
            end
            mieu_pkg::OP_BEQ:  if (a_q == b_q) e_npc = btgt;
            mieu_pkg::OP_BNE:  if (a_q != b_q) e_npc = btgt;
            mieu_pkg::OP_BLEZ: if (a_q[31] || a_q == 32'd0) e_npc = btgt;
            mieu_pkg::OP_BGTZ: if (!a_q[31] && a_q != 32'd0) e_npc = btgt;
            mieu_pkg::OP_ADDI, mieu_pkg::OP_ADDIU: begin
              e_wen = 1'b1; e_wreg = f_rt; e_wval = a_q + simm;
            end
            mieu_pkg::OP_SLTI: begin
              e_wen = 1'b1; e_wreg = f_rt; e_wval = {31'd0, $signed(a_q) < $signed(simm)};
            end
            mieu_pkg::OP_SLTIU: begin
              e_wen = 1'b1; e_wreg = f_rt; e_wval = {31'd0, a_q < simm};
            end
            mieu_pkg::OP_ANDI: begin
              e_wen = 1'b1; e_wreg = f_rt; e_wval = a_q & zimm;
            end
            mieu_pkg::OP_ORI: begin
              e_wen = 1'b1; e_wreg = f_rt; e_wval = a_q | zimm;
            end
            mieu_pkg::OP_XORI: begin
              e_wen = 1'b1; e_wreg = f_rt; e_wval = a_q ^ zimm;
            end
            mieu_pkg::OP_LUI: begin
              e_wen = 1'b1; e_wreg = f_rt; e_wval = {instr_q[15:0], 16'h0000};
            end
            mieu_pkg::OP_LB: begin
              e_addr = a_q + simm; e_req = mieu_pkg::REQ_LB;
              e_ld_set = 1'b1; e_lkind = mieu_pkg::LK_LB;
            end
            mieu_pkg::OP_LBU: begin
              e_addr = a_q + simm; e_req = mieu_pkg::REQ_LBU;
              e_ld_set = 1'b1; e_lkind = mieu_pkg::LK_LBU;
            end
            mieu_pkg::OP_LW: begin
              e_addr = a_q + simm; e_req = mieu_pkg::REQ_LW;
              e_ld_set = 1'b1; e_lkind = mieu_pkg::LK_LW;
            end
            mieu_pkg::OP_SB: begin
              e_addr = a_q + simm; e_sdata = b_q; e_req = mieu_pkg::REQ_SB;
            end
            mieu_pkg::OP_SW: begin
              e_addr = a_q + simm; e_sdata = b_q; e_req = mieu_pkg::REQ_SW;
            end
            default: ;
          endcase
        end
      end
      mieu_pkg::KIND_LOAD: begin
        e_npc = pc_q;
        if (lpend_q) begin
          e_ld_clr = 1'b1;
          e_wen = 1'b1; e_wreg = ldest_q; e_wval = e_ldv;
        end else begin
          e_status = 1'b1;
        end
      end
      default: begin
        e_status = 1'b1;
        e_npc = pc_q;
      end
    endcase
    // r0 is never written
    if (e_wreg == 5'd0) begin
      e_wen = 1'b0;
    end
    if (!e_wen) begin
      e_wreg = 5'd0;
      e_wval = 32'd0;
    end
  end

  // shared add/subtract step for multiply (shift-add) and divide (restoring);
  // the divide compare keeps the remainder bit shifted out of the top
  always_comb begin
    md_sh = {md_acc_q[62:0], 1'b0};
    if (md_div_q) begin
      md_sum = {md_acc_q[63], md_sh[63:32]} + {1'b1, ~md_op_q} + 33'd1;
      md_acc_d = md_sum[32] ? md_sh : {md_sum[31:0], md_sh[31:1], 1'b1};
    end else begin
      md_sum = {1'b0, md_acc_q[63:32]} + (md_acc_q[0] ? {1'b0, md_op_q} : 33'd0);
      md_acc_d = {md_sum, md_acc_q[31:1]};
    end
    md_prod = md_negq_q ? (64'd0 - md_acc_q) : md_acc_q;
    if (md_div_q) begin
      md_lo = md_negq_q ? (32'd0 - md_acc_q[31:0]) : md_acc_q[31:0];
      md_hi = md_negr_q ? (32'd0 - md_acc_q[63:32]) : md_acc_q[63:32];
    end else begin
      md_lo = md_prod[31:0];
      md_hi = md_prod[63:32];
    end
  end

  // register file write port
  always_comb begin
    rf_we = 1'b0;
    rf_waddr = e_wreg;
    rf_wdata = e_wval;
    case (state_q)
      S_EXEC: rf_we = out_free && !e_md_start && e_wen;
      S_BOOT: begin
        case (bcnt_q)
          2'd0: begin
            rf_we = 1'b1; rf_waddr = mieu_pkg::REG_GP; rf_wdata = cfg_gp_q;
          end
          2'd1: begin
            rf_we = 1'b1; rf_waddr = mieu_pkg::REG_SP; rf_wdata = cfg_sp_q;
          end
          default: begin
            rf_we = out_free; rf_waddr = mieu_pkg::REG_RA; rf_wdata = cfg_pc_q;
          end
        endcase
      end
      default: ;
    endcase
  end

  // register file storage and registered reads
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (state_q == S_IDLE && in_valid_i) begin
      a_q <= rf_vld_q[rd_a] ? rf_mem[rd_a] : 32'd0;
      b_q <= rf_vld_q[rd_b] ? rf_mem[rd_b] : 32'd0;
    end
  end

  // sequencer, architectural state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rf_vld_q    <= 32'd0;
      pc_q        <= 32'd0;
      hi_q        <= 32'd0;
      lo_q        <= 32'd0;
      lpend_q     <= 1'b0;
      ldest_q     <= 5'd0;
      lkind_q     <= mieu_pkg::LK_LB;
      cfg_pc_q    <= 32'd0;
      cfg_gp_q    <= 32'd0;
      cfg_sp_q    <= 32'd0;
      bcnt_q      <= 2'd0;
      md_cnt_q    <= 5'd0;
      out_valid_q <= 1'b0;
      kind_q      <= mieu_pkg::KIND_EXEC;
      instr_q     <= 32'd0;
      ld_q        <= 32'd0;
      md_acc_q    <= 64'd0;
      md_op_q     <= 32'd0;
      md_div_q    <= 1'b0;
      md_negq_q   <= 1'b0;
      md_negr_q   <= 1'b0;
      o_npc_q     <= 32'd0;
      o_req_q     <= mieu_pkg::REQ_NONE;
      o_addr_q    <= 32'd0;
      o_sdata_q   <= 32'd0;
      o_code_q    <= 16'd0;
      o_wen_q     <= 1'b0;
      o_wreg_q    <= 5'd0;
      o_wval_q    <= 32'd0;
      o_status_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          mieu_pkg::CFG_START_PC: cfg_pc_q <= cfg_data_i;
          mieu_pkg::CFG_GP:       cfg_gp_q <= cfg_data_i;
          mieu_pkg::CFG_SP:       cfg_sp_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= kind_i;
            instr_q <= instr_i;
            ld_q    <= load_data_i;
            bcnt_q  <= 2'd0;
            state_q <= (kind_i == mieu_pkg::KIND_BOOT) ? S_BOOT : S_EXEC;
          end
        end
        S_EXEC: begin
          if (e_md_start) begin
            md_div_q  <= e_md_div;
            md_cnt_q  <= 5'd0;
            md_acc_q  <= {32'd0, e_md_div ? (e_md_sgn ? abs_a : a_q)
                                          : (e_md_sgn ? abs_b : b_q)};
            md_op_q   <= e_md_div ? (e_md_sgn ? abs_b : b_q) : (e_md_sgn ? abs_a : a_q);
            md_negq_q <= e_md_sgn && (a_q[31] ^ b_q[31]);
            md_negr_q <= e_md_sgn && a_q[31];
            state_q   <= S_MDU;
          end else if (out_free) begin
            pc_q <= e_npc;
            if (e_hi_we) hi_q <= e_hiv;
            if (e_lo_we) lo_q <= e_lov;
            if (e_ld_set) begin
              lpend_q <= 1'b1;
              ldest_q <= f_rt;
              lkind_q <= e_lkind;
            end
            if (e_ld_clr) lpend_q <= 1'b0;
            out_valid_q <= 1'b1;
            o_npc_q     <= e_npc;
            o_req_q     <= e_req;
            o_addr_q    <= e_addr;
            o_sdata_q   <= e_sdata;
            o_code_q    <= e_code;
            o_wen_q     <= e_wen;
            o_wreg_q    <= e_wreg;
            o_wval_q    <= e_wval;
            o_status_q  <= e_status;
            state_q     <= S_IDLE;
          end
        end
        S_BOOT: begin
          if (bcnt_q != 2'd2) begin
            bcnt_q <= bcnt_q + 2'd1;
          end else if (out_free) begin
            pc_q        <= cfg_pc_q;
            lpend_q     <= 1'b0;
            out_valid_q <= 1'b1;
            o_npc_q     <= cfg_pc_q;
            o_req_q     <= mieu_pkg::REQ_NONE;
            o_addr_q    <= 32'd0;
            o_sdata_q   <= 32'd0;
            o_code_q    <= 16'd0;
            o_wen_q     <= 1'b0;
            o_wreg_q    <= 5'd0;
            o_wval_q    <= 32'd0;
            o_status_q  <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        S_MDU: begin
          md_acc_q <= md_acc_d;
          md_cnt_q <= md_cnt_q + 5'd1;
          if (md_cnt_q == mieu_pkg::MD_LAST) begin
            state_q <= S_MFIN;
          end
        end
        S_MFIN: begin
          if (out_free) begin
            hi_q        <= md_hi;
            lo_q        <= md_lo;
            pc_q        <= link;
            out_valid_q <= 1'b1;
            o_npc_q     <= link;
            o_req_q     <= mieu_pkg::REQ_NONE;
            o_addr_q    <= 32'd0;
            o_sdata_q   <= 32'd0;
            o_code_q    <= 16'd0;
            o_wen_q     <= 1'b0;
            o_wreg_q    <= 5'd0;
            o_wval_q    <= 32'd0;
            o_status_q  <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign next_pc_o      = o_npc_q;
  assign request_o      = o_req_q;
  assign mem_addr_o     = o_addr_q;
  assign store_data_o   = o_sdata_q;
  assign syscall_code_o = o_code_q;
  assign wr_en_o        = o_wen_q;
  assign wr_reg_o       = o_wreg_q;
  assign wr_value_o     = o_wval_q;
  assign status_o       = o_status_q;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] KIND_NONE = 2'd3;  // kind code with no meaning
  localparam logic [5:0] FN_BREAK  = 6'h0D;
  localparam logic [4:0] RI_UNDEF  = 5'h05;  // REGIMM code with no meaning
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] instr;
    logic [31:0] load_data;
  } word_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [2:0]  request;
    logic [31:0] mem_addr;
    logic [31:0] store_data;
    logic [15:0] syscall_code;
    logic        wr_en;
    logic [4:0]  wr_reg;
    logic [31:0] wr_value;
    logic        status;
  } retire_t;

  logic clk_i;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = mieu_pkg::KIND_EXEC;
  logic [31:0] instr = '0;
  logic [31:0] load_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] next_pc;
  logic [2:0]  request;
  logic [31:0] mem_addr;
  logic [31:0] store_data;
  logic [15:0] syscall_code;
  logic        wr_en;
  logic [4:0]  wr_reg;
  logic [31:0] wr_value;
  logic        status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = mieu_pkg::CFG_START_PC;
  logic [31:0] cfg_data = '0;

  mips_integer_execute_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .instr_i        (instr),
    .load_data_i    (load_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .next_pc_o      (next_pc),
    .request_o      (request),
    .mem_addr_o     (mem_addr),
    .store_data_o   (store_data),
    .syscall_code_o (syscall_code),
    .wr_en_o        (wr_en),
    .wr_reg_o       (wr_reg),
    .wr_value_o     (wr_value),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // architectural state mirror
  logic [31:0] arch_gpr [32];
  logic [31:0] arch_hi, arch_lo, arch_pc;
  logic        arch_ld_pend;
  logic [4:0]  arch_ld_dest;
  logic [1:0]  arch_ld_kind;
  logic [31:0] cfg_start_pc, cfg_gp, cfg_sp;

  word_t   issue_q[$];
  retire_t retire_q[$];
  int unsigned mismatches = 0;

  // runs one word against the mirror and returns the retirement it causes
  function automatic retire_t retire_word(input word_t w);
    retire_t r;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh, dst;
    logic [31:0] a, b, simm, zimm, link, btgt, npc, val;
    logic        wr;
    logic [63:0] prod;
    r = '0;
    wr = 1'b0;
    dst = '0;
    val = '0;
    op = w.instr[31:26];
    fn = w.instr[5:0];
    rs = w.instr[25:21];
    rt = w.instr[20:16];
    rd = w.instr[15:11];
    sh = w.instr[10:6];
    a = arch_gpr[rs];
    b = arch_gpr[rt];
    simm = {{16{w.instr[15]}}, w.instr[15:0]};
    zimm = {16'h0, w.instr[15:0]};
    link = arch_pc + 32'd4;
    btgt = link + (simm << 2);
    npc = link;
    if (w.kind == mieu_pkg::KIND_BOOT) begin
      arch_gpr[mieu_pkg::REG_GP] = cfg_gp;
      arch_gpr[mieu_pkg::REG_SP] = cfg_sp;
      arch_gpr[mieu_pkg::REG_RA] = cfg_start_pc;
      arch_pc = cfg_start_pc;
      arch_ld_pend = 1'b0;
    end else if (w.kind == mieu_pkg::KIND_EXEC && !arch_ld_pend) begin
      case (op)
        mieu_pkg::OP_SPECIAL: begin
          dst = rd;
          case (fn)
            mieu_pkg::FN_ADD, mieu_pkg::FN_ADDU: begin wr = 1'b1; val = a + b; end
            mieu_pkg::FN_SUB, mieu_pkg::FN_SUBU: begin wr = 1'b1; val = a - b; end
            mieu_pkg::FN_AND: begin wr = 1'b1; val = a & b; end
            mieu_pkg::FN_OR:  begin wr = 1'b1; val = a | b; end
            mieu_pkg::FN_XOR: begin wr = 1'b1; val = a ^ b; end
            mieu_pkg::FN_NOR: begin wr = 1'b1; val = ~(a | b); end
            mieu_pkg::FN_SLT: begin wr = 1'b1; val = {31'b0, $signed(a) < $signed(b)}; end
            mieu_pkg::FN_SLTU: begin wr = 1'b1; val = {31'b0, a < b}; end
            mieu_pkg::FN_SLL: begin wr = 1'b1; val = b << sh; end
            mieu_pkg::FN_SRL: begin wr = 1'b1; val = b >> sh; end
            mieu_pkg::FN_SRA: begin wr = 1'b1; val = $signed(b) >>> sh; end
            mieu_pkg::FN_SLLV: begin wr = 1'b1; val = b << a[4:0]; end
            mieu_pkg::FN_SRLV: begin wr = 1'b1; val = b >> a[4:0]; end
            mieu_pkg::FN_SRAV: begin wr = 1'b1; val = $signed(b) >>> a[4:0]; end
            mieu_pkg::FN_MFHI: begin wr = 1'b1; val = arch_hi; end
            mieu_pkg::FN_MTHI: arch_hi = a;
            mieu_pkg::FN_MFLO: begin wr = 1'b1; val = arch_lo; end
            mieu_pkg::FN_MTLO: arch_lo = a;
            mieu_pkg::FN_MULT: begin
              prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
              {arch_hi, arch_lo} = prod;
            end
            mieu_pkg::FN_MULTU: begin
              prod = {32'h0, a} * {32'h0, b};
              {arch_hi, arch_lo} = prod;
            end
            mieu_pkg::FN_DIV: begin
              // zero divisor leaves HI/LO alone; most-negative / -1 wraps
              if (b == 32'h0000_0000) begin
              end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                arch_lo = 32'h8000_0000;
                arch_hi = '0;
              end else begin
                arch_lo = $signed(a) / $signed(b);
                arch_hi = $signed(a) % $signed(b);
              end
            end
            mieu_pkg::FN_DIVU: if (b != '0) begin
              arch_lo = a / b;
              arch_hi = a % b;
            end
            mieu_pkg::FN_JR: npc = a;
            mieu_pkg::FN_JALR: begin npc = a; wr = 1'b1; val = link; end
            mieu_pkg::FN_SYSCALL: begin
              r.request = mieu_pkg::REQ_SYS;
              r.syscall_code = arch_gpr[mieu_pkg::REG_V0][15:0];
            end
            default: ;
          endcase
        end
        mieu_pkg::OP_REGIMM: begin
          case (rt)
            mieu_pkg::RI_BLTZ: if (a[31]) npc = btgt;
            mieu_pkg::RI_BGEZ: if (!a[31]) npc = btgt;
            mieu_pkg::RI_BLTZAL: begin
              if (a[31]) npc = btgt;
              wr = 1'b1; dst = mieu_pkg::REG_RA; val = link;
            end
            mieu_pkg::RI_BGEZAL: begin
              if (!a[31]) npc = btgt;
              wr = 1'b1; dst = mieu_pkg::REG_RA; val = link;
            end
            default: ;
          endcase
        end
        mieu_pkg::OP_J: npc = {link[31:28], w.instr[25:0], 2'b00};
        mieu_pkg::OP_JAL: begin
          npc = {link[31:28], w.instr[25:0], 2'b00};
          wr = 1'b1; dst = mieu_pkg::REG_RA; val = link;
        end
        mieu_pkg::OP_BEQ: if (a == b) npc = btgt;
        mieu_pkg::OP_BNE: if (a != b) npc = btgt;
        mieu_pkg::OP_BLEZ: if ($signed(a) <= 0) npc = btgt;
        mieu_pkg::OP_BGTZ: if ($signed(a) > 0) npc = btgt;
        mieu_pkg::OP_ADDI, mieu_pkg::OP_ADDIU: begin
          wr = 1'b1; dst = rt; val = a + simm;
        end
        mieu_pkg::OP_SLTI: begin
          wr = 1'b1; dst = rt; val = {31'b0, $signed(a) < $signed(simm)};
        end
        mieu_pkg::OP_SLTIU: begin wr = 1'b1; dst = rt; val = {31'b0, a < simm}; end
        mieu_pkg::OP_ANDI: begin wr = 1'b1; dst = rt; val = a & zimm; end
        mieu_pkg::OP_ORI: begin wr = 1'b1; dst = rt; val = a | zimm; end
        mieu_pkg::OP_XORI: begin wr = 1'b1; dst = rt; val = a ^ zimm; end
        mieu_pkg::OP_LUI: begin wr = 1'b1; dst = rt; val = zimm << 16; end
        mieu_pkg::OP_LB, mieu_pkg::OP_LBU, mieu_pkg::OP_LW: begin
          r.mem_addr = a + simm;
          r.request = (op == mieu_pkg::OP_LB) ? mieu_pkg::REQ_LB :
                      (op == mieu_pkg::OP_LBU) ? mieu_pkg::REQ_LBU : mieu_pkg::REQ_LW;
          arch_ld_kind = (op == mieu_pkg::OP_LB) ? mieu_pkg::LK_LB :
                         (op == mieu_pkg::OP_LBU) ? mieu_pkg::LK_LBU : mieu_pkg::LK_LW;
          arch_ld_pend = 1'b1;
          arch_ld_dest = rt;
        end
        mieu_pkg::OP_SB, mieu_pkg::OP_SW: begin
          r.mem_addr = a + simm;
          r.store_data = b;
          r.request = (op == mieu_pkg::OP_SB) ? mieu_pkg::REQ_SB : mieu_pkg::REQ_SW;
        end
        default: ;
      endcase
      arch_pc = npc;
    end else if (w.kind == mieu_pkg::KIND_LOAD && arch_ld_pend) begin
      wr = 1'b1;
      dst = arch_ld_dest;
      case (arch_ld_kind)
        mieu_pkg::LK_LB:  val = {{24{w.load_data[7]}}, w.load_data[7:0]};
        mieu_pkg::LK_LBU: val = {24'h0, w.load_data[7:0]};
        default: val = w.load_data;
      endcase
      arch_ld_pend = 1'b0;
    end else begin
      r.status = 1'b1;
    end
    // r0 writes are dropped
    if (wr && dst != '0) begin
      arch_gpr[dst] = val;
      r.wr_en = 1'b1;
      r.wr_reg = dst;
      r.wr_value = val;
    end
    r.next_pc = arch_pc;
    return r;
  endfunction

  // sender: bursts of words with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_n) begin
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall)
        retire_q.push_back(retire_word('{kind, instr, load_data}));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (issue_q.size() > 0) begin
          w = issue_q.pop_front();
          in_valid <= 1'b1;
          kind <= w.kind;
          instr <= w.instr;
          load_data <= w.load_data;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h at %0t", name, exp_v, got_v, $realtime);
    end
  endfunction

  // receiver: random stall patterns; result checking
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;
  always @(posedge clk_i or negedge rst_n) begin
    retire_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_tick <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (retire_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          e = retire_q.pop_front();
          check_field("next_pc", e.next_pc, next_pc);
          check_field("request", e.request, request);
          check_field("mem_addr", e.mem_addr, mem_addr);
          check_field("store_data", e.store_data, store_data);
          check_field("syscall_code", e.syscall_code, syscall_code);
          check_field("wr_en", e.wr_en, wr_en);
          check_field("wr_reg", e.wr_reg, wr_reg);
          check_field("wr_value", e.wr_value, wr_value);
          check_field("status", e.status, status);
        end
      end
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_tick[2];
      endcase
    end
  end

  // instruction encoders
  function automatic logic [31:0] enc_r(input logic [5:0] f, input logic [4:0] s,
                                        input logic [4:0] t, input logic [4:0] d,
                                        input logic [4:0] a);
    return {mieu_pkg::OP_SPECIAL, s, t, d, a, f};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] o, input logic [4:0] s,
                                        input logic [4:0] t, input logic [15:0] imm);
    return {o, s, t, imm};
  endfunction

  function automatic logic [4:0] pick_reg();
    case ($urandom_range(0, 7))
      0: return 5'($urandom_range(0, 31));
      1: return 5'($urandom_range(28, 31));
      default: return 5'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  logic [5:0] alu_fns [12] = '{mieu_pkg::FN_ADD, mieu_pkg::FN_ADDU, mieu_pkg::FN_SUB,
                               mieu_pkg::FN_SUBU, mieu_pkg::FN_AND, mieu_pkg::FN_OR,
                               mieu_pkg::FN_XOR, mieu_pkg::FN_NOR, mieu_pkg::FN_SLT,
                               mieu_pkg::FN_SLTU, mieu_pkg::FN_SLLV, mieu_pkg::FN_SRLV};
  logic [5:0] imm_ops [8] = '{mieu_pkg::OP_ADDI, mieu_pkg::OP_ADDIU, mieu_pkg::OP_SLTI,
                              mieu_pkg::OP_SLTIU, mieu_pkg::OP_ANDI, mieu_pkg::OP_ORI,
                              mieu_pkg::OP_XORI, mieu_pkg::OP_LUI};
  logic [5:0] br_ops [4] = '{mieu_pkg::OP_BEQ, mieu_pkg::OP_BNE, mieu_pkg::OP_BLEZ,
                             mieu_pkg::OP_BGTZ};
  logic [5:0] md_fns [8] = '{mieu_pkg::FN_MULT, mieu_pkg::FN_MULTU, mieu_pkg::FN_DIV,
                             mieu_pkg::FN_DIVU, mieu_pkg::FN_MFHI, mieu_pkg::FN_MTHI,
                             mieu_pkg::FN_MFLO, mieu_pkg::FN_MTLO};
  logic [4:0] ri_codes [5] = '{mieu_pkg::RI_BLTZ, mieu_pkg::RI_BGEZ, mieu_pkg::RI_BLTZAL,
                               mieu_pkg::RI_BGEZAL, RI_UNDEF};

  function automatic logic [31:0] random_instr();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: return enc_r(alu_fns[$urandom_range(0, 11)], pick_reg(), pick_reg(),
                                  pick_reg(), 5'($urandom));
      5: return enc_r($urandom_range(0, 1) ? mieu_pkg::FN_SRA : mieu_pkg::FN_SRAV,
                      pick_reg(), pick_reg(), pick_reg(), 5'($urandom));
      6: return enc_r($urandom_range(0, 1) ? mieu_pkg::FN_SLL : mieu_pkg::FN_SRL,
                      pick_reg(), pick_reg(), pick_reg(), 5'($urandom));
      7, 8: return enc_r(md_fns[$urandom_range(0, 7)], pick_reg(), pick_reg(), pick_reg(),
                         5'd0);
      9, 10, 11: return enc_i(imm_ops[$urandom_range(0, 7)], pick_reg(), pick_reg(),
                              pick_imm());
      12: return enc_i(br_ops[$urandom_range(0, 3)], pick_reg(), pick_reg(), pick_imm());
      13: return enc_i(mieu_pkg::OP_REGIMM, pick_reg(), ri_codes[$urandom_range(0, 4)],
                       pick_imm());
      14: return {$urandom_range(0, 1) ? mieu_pkg::OP_J : mieu_pkg::OP_JAL, 26'($urandom)};
      15: return enc_r($urandom_range(0, 1) ? mieu_pkg::FN_JR : mieu_pkg::FN_JALR,
                       pick_reg(), 5'd0, pick_reg(), 5'd0);
      16: return enc_i($urandom_range(0, 1) ? mieu_pkg::OP_LB :
                       ($urandom_range(0, 1) ? mieu_pkg::OP_LBU : mieu_pkg::OP_LW),
                       pick_reg(), pick_reg(), pick_imm());
      17: return enc_i($urandom_range(0, 1) ? mieu_pkg::OP_SB : mieu_pkg::OP_SW,
                       pick_reg(), pick_reg(), pick_imm());
      18: return enc_r(mieu_pkg::FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0);
      default: return $urandom;
    endcase
  endfunction

  function automatic bit is_load(input logic [31:0] w);
    return w[31:26] == mieu_pkg::OP_LB || w[31:26] == mieu_pkg::OP_LBU ||
           w[31:26] == mieu_pkg::OP_LW;
  endfunction

  task automatic push_word(input logic [1:0] k, input logic [31:0] i, input logic [31:0] d);
    issue_q.push_back('{k, i, d});
  endtask

  // writes all three registers back to back, then drops valid
  task automatic write_config(input logic [31:0] spc, input logic [31:0] gp,
                              input logic [31:0] sp);
    logic [31:0] vals [3];
    vals = '{spc, gp, sp};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      do @(posedge clk_i); while (!cfg_ready);
      case (2'(i))
        mieu_pkg::CFG_START_PC: cfg_start_pc = vals[i];
        mieu_pkg::CFG_GP: cfg_gp = vals[i];
        default: cfg_sp = vals[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (issue_q.size() > 0 || in_valid || retire_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // load-aware random program: loads are mostly followed by their data
  task automatic random_program(input int unsigned count);
    bit load_open;
    logic [31:0] w;
    load_open = 1'b0;
    push_word(mieu_pkg::KIND_BOOT, $urandom, $urandom);
    for (int n = 0; n < count; n++) begin
      if (load_open) begin
        case ($urandom_range(0, 19))
          0: push_word(mieu_pkg::KIND_EXEC, random_instr(), $urandom);
          1: push_word(KIND_NONE, $urandom, $urandom);
          2: begin
            push_word(mieu_pkg::KIND_BOOT, $urandom, $urandom);
            load_open = 1'b0;
          end
          default: begin
            push_word(mieu_pkg::KIND_LOAD, $urandom, $urandom);
            load_open = 1'b0;
          end
        endcase
      end else begin
        case ($urandom_range(0, 39))
          0: push_word(mieu_pkg::KIND_LOAD, $urandom, $urandom);
          1: push_word(KIND_NONE, $urandom, $urandom);
          2: push_word(mieu_pkg::KIND_BOOT, $urandom, $urandom);
          default: begin
            w = random_instr();
            push_word(mieu_pkg::KIND_EXEC, w, $urandom);
            load_open = is_load(w);
          end
        endcase
      end
    end
  endtask

  // stimulus
  initial begin
    for (int i = 0; i < 32; i++) arch_gpr[i] = '0;
    arch_hi = '0; arch_lo = '0; arch_pc = '0;
    arch_ld_pend = 1'b0; arch_ld_dest = '0; arch_ld_kind = mieu_pkg::LK_LB;
    cfg_start_pc = '0; cfg_gp = '0; cfg_sp = '0;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and corner cases
    write_config(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h8000_0000);
    push_word(mieu_pkg::KIND_BOOT, 32'd0, 32'd0);
    push_word(mieu_pkg::KIND_EXEC, enc_i(mieu_pkg::OP_LUI, 5'd0, 5'd1, 16'hFFFF), 32'd0);
    push_word(mieu_pkg::KIND_EXEC, enc_i(mieu_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF),
              32'd0);                                                    // r1 = -1
    push_word(mieu_pkg::KIND_EXEC, enc_i(mieu_pkg::OP_LUI, 5'd0, 5'd2, 16'h8000),
              32'd0);                                                    // r2 = min int
    push_word(mieu_pkg::KIND_EXEC, enc_r(mieu_pkg::FN_DIV, 5'd2, 5'd1, 5'd0, 5'd0),
              32'd0);                                                    // overflowing divide
    push_word(mieu_pkg::KIND_EXEC, enc_r(mieu_pkg::FN_MFLO, 5'd0, 5'd0, 5'd3, 5'd0), 32'd0);
    push_word(mieu_pkg::KIND_EXEC, enc_r(mieu_pkg::FN_MFHI, 5'd0, 5'd0, 5'd4, 5'd0), 32'd0);
    push_word(mieu_pkg::KIND_EXEC, enc_r(mieu_pkg::FN_DIVU, 5'd1, 5'd0, 5'd0, 5'd0),
              32'd0);                                                    // divide by zero
    push_word(mieu_pkg::KIND_EXEC, enc_r(mieu_pkg::FN_MULT, 5'd2, 5'd2, 5'd0, 5'd0), 32'd0);
    push_word(mieu_pkg::KIND_EXEC, enc_r(mieu_pkg::FN_MULTU, 5'd1, 5'd1, 5'd0, 5'd0), 32'd0);
    push_word(mieu_pkg::KIND_EXEC, enc_r(mieu_pkg::FN_SRAV, 5'd1, 5'd2, 5'd5, 5'd0),
              32'd0);                                                    // shift amount mod 32
    push_word(mieu_pkg::KIND_EXEC, enc_r(mieu_pkg::FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0),
              32'd0);
    push_word(mieu_pkg::KIND_EXEC,
              enc_i(mieu_pkg::OP_REGIMM, 5'd0, mieu_pkg::RI_BLTZAL, 16'h8000),
              32'd0);                                                    // not taken, links
    push_word(mieu_pkg::KIND_EXEC, enc_r(mieu_pkg::FN_JALR, 5'd1, 5'd0, 5'd1, 5'd0),
              32'd0);                                                    // rs equals rd
    push_word(mieu_pkg::KIND_EXEC, {mieu_pkg::OP_JAL, 26'h3FF_FFFF}, 32'd0);
    push_word(mieu_pkg::KIND_EXEC, enc_i(mieu_pkg::OP_LB, 5'd2, 5'd0, 16'hFFFF),
              32'd0);                                                    // load into r0
    push_word(mieu_pkg::KIND_EXEC, enc_i(mieu_pkg::OP_ADDI, 5'd0, 5'd6, 16'h7FFF),
              32'd0);                                                    // ignored, load pending
    push_word(mieu_pkg::KIND_LOAD, 32'd0, 32'hFFFF_FF80);
    push_word(mieu_pkg::KIND_LOAD, 32'd0, 32'h1234_5678);               // nothing pending
    push_word(mieu_pkg::KIND_EXEC, enc_i(mieu_pkg::OP_LB, 5'd1, 5'd7, 16'h0001), 32'd0);
    push_word(mieu_pkg::KIND_LOAD, 32'd0, 32'h0000_0080);
    push_word(mieu_pkg::KIND_EXEC, enc_i(mieu_pkg::OP_SB, 5'd1, 5'd7, 16'h8000), 32'd0);
    push_word(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(mieu_pkg::KIND_EXEC, 32'hFFFF_FFFF, 32'd0);               // undefined opcode
    push_word(mieu_pkg::KIND_EXEC, enc_r(FN_BREAK, 5'd0, 5'd0, 5'd0, 5'd0), 32'd0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_config('0, '0, '0);
        1: write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: write_config($urandom, $urandom, $urandom);
      endcase
      random_program(250);
      wait_idle();
    end

    if (mismatches == 0 && retire_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### mips_integer_execute_unit.f
rtl/mieu_pkg.sv
rtl/mips_integer_execute_unit.sv
tb/sv/testbench.sv
